>>> hw/rtl/tlb_fifo_lru_translate_core_macros.svh
// Assertion macros used by the port-level checker
`ifndef TLB_FIFO_LRU_TRANSLATE_CORE_MACROS_SVH
`define TLB_FIFO_LRU_TRANSLATE_CORE_MACROS_SVH
// implication checked on every rising edge outside reset
`define TLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlb assertion failed");
// next-cycle implication checked outside reset
`define TLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlb assertion failed");
`endif

>>> hw/rtl/tlbflt_pkg.sv
// Package: shared types, constants and command codes of the TLB
`default_nettype none
package tlbflt_pkg;
  localparam int TlbDepth   = 16;
  localparam int IdxW       = $clog2(TlbDepth);
  localparam int CntW       = $clog2(TlbDepth + 1);
  localparam int StampW     = 32;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;
  localparam logic [1:0] CMD_FLUSH  = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_PSIZE  = 2'd1;
  localparam logic [1:0] REG_EPT    = 2'd2;
  localparam logic [1:0] REG_NUSE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture incoming transaction, start first divide
    logic div1_start; // start page / ept
    logic scan_start; // start entry search
    logic finish;     // apply update and present result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/tlbflt_div.sv
// Restoring 32-bit by 17-bit divider, one quotient bit per cycle
`default_nettype none
module tlbflt_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [16:0]      remainder
);
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] trial;
  logic [18:0] diff;
  logic [31:0] q_step;
  logic [16:0] rem_step;

  // shift in next dividend bit and try subtract
  always_comb begin
    trial    = {rem_r, q_r[31]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    q_step   = {q_r[30:0], ~diff[18]};
    rem_step = diff[18] ? trial[16:0] : diff[16:0];
  end

  // load on start, else advance one bit while busy
  always_comb begin
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = (divisor == '0) ? 17'd1 : divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = busy_r && (cnt_r == 6'd1);
  assign quotient  = q_step;
  assign remainder = rem_step;
endmodule
`default_nettype wire

>>> hw/rtl/tlbflt_ctrl.sv
// Controller: sequences divide, entry scan and result handoff
`default_nettype none
module tlbflt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tlbflt_pkg::dp_cmd_t    cmd,
  input  wire tlbflt_pkg::dp_sts_t sts
);
  tlbflt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbflt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      tlbflt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tlbflt_pkg::ST_DIV1;
        end
      end
      tlbflt_pkg::ST_DIV1: begin
        if (sts.div_done) begin
          cmd.div1_start = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = tlbflt_pkg::ST_DIV2;
        end
      end
      tlbflt_pkg::ST_DIV2: begin
        if (sts.div_done) state_nxt = tlbflt_pkg::ST_SCAN;
      end
      tlbflt_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = tlbflt_pkg::ST_DONE;
        end
      end
      tlbflt_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = tlbflt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlbflt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/tlbflt_dp.sv
// Datapath: entry arrays, shared divider, sequential search and victim scan
`default_nettype none
module tlbflt_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_data,
  input  wire tlbflt_pkg::dp_cmd_t cmd,
  output tlbflt_pkg::dp_sts_t      sts,
  input  wire logic [1:0]          in_command,
  input  wire logic [31:0]         in_logical_address,
  input  wire logic [31:0]         in_frame_base,
  output logic                     out_hit,
  output logic [31:0]              out_physical_address,
  output logic [31:0]              out_page_number,
  output logic [31:0]              out_first_level_index,
  output logic [15:0]              out_second_level_index,
  output logic [3:0]               out_entry_index,
  output logic [4:0]               out_freed_count
);
  localparam int D  = tlbflt_pkg::TlbDepth;
  localparam int IW = tlbflt_pkg::IdxW;
  localparam int CW = tlbflt_pkg::CntW;
  localparam int SW = tlbflt_pkg::StampW;

  // configuration
  logic        policy_r;
  logic [16:0] psize_r, ept_r;
  logic [4:0]  nuse_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      psize_r  <= 17'd64;
      ept_r    <= 17'd4;
      nuse_r   <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlbflt_pkg::REG_POLICY: policy_r <= cfg_data[0];
        tlbflt_pkg::REG_PSIZE:  psize_r  <= cfg_data;
        tlbflt_pkg::REG_EPT:    ept_r    <= cfg_data;
        tlbflt_pkg::REG_NUSE:   nuse_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp entry count to 1..D
  logic [CW-1:0] n_act;
  always_comb begin
    if (nuse_r == 5'd0) n_act = CW'(1);
    else if (32'(nuse_r) > D) n_act = CW'(D);
    else n_act = CW'(nuse_r);
  end

  // captured transaction
  logic [1:0]  cmd_r;
  logic [31:0] addr_r, frame_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      addr_r  <= in_logical_address;
      frame_r <= in_frame_base;
    end
  end

  // shared divider: first address / page size, then page / ept
  logic        div_start, div_done;
  logic [31:0] div_a, div_q;
  logic [16:0] div_b, div_rem;
  logic [31:0] page_r, offset_r;
  assign div_start = cmd.load | cmd.div1_start;
  assign div_a     = cmd.load ? in_logical_address : div_q;
  assign div_b     = cmd.load ? psize_r : ept_r;
  tlbflt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_rem)
  );
  always_ff @(posedge clk) begin
    if (cmd.div1_start) begin
      page_r   <= div_q;
      offset_r <= 32'(div_rem);
    end
  end
  logic [31:0] l1_r;
  logic [15:0] l2_r;
  logic        div2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div2_r <= 1'b0;
    else if (cmd.div1_start) div2_r <= 1'b1;
    else if (div_done) div2_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (div2_r && div_done) begin
      l1_r <= div_q;
      l2_r <= div_rem[15:0];
    end
  end

  // entry storage
  logic [D-1:0]  valid_r;
  logic [31:0]   page_mem [D];
  logic [31:0]   frame_mem [D];
  logic [SW-1:0] use_r [D];
  logic [SW-1:0] ins_r [D];
  logic [SW-1:0] evt_r;

  // scan: one entry per cycle
  logic          scan_busy_r;
  logic [CW-1:0] scan_i_r;
  logic [IW-1:0] sidx;
  logic          found_r;
  logic [IW-1:0] found_idx_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic [IW-1:0] best_r;
  logic [SW-1:0] best_stamp_r;
  logic [CW-1:0] freed_r;
  logic [CW-1:0] scan_lim;
  logic          is_mgmt;
  logic [SW-1:0] cur_stamp;
  logic          match, kill;
  logic          scan_done;
  logic [IW-1:0] fill_idx;
  assign is_mgmt  = cmd_r[1];
  assign scan_lim = is_mgmt ? CW'(D) : n_act;
  assign sidx     = scan_i_r[IW-1:0];
  assign cur_stamp = policy_r ? use_r[sidx] : ins_r[sidx];
  assign match = valid_r[sidx] && (page_mem[sidx] == page_r);
  assign kill  = valid_r[sidx] &&
                 ((cmd_r == tlbflt_pkg::CMD_FLUSH) || (frame_mem[sidx] == frame_r));
  assign scan_done = scan_busy_r && !div2_r && (scan_i_r == scan_lim);
  assign sts       = '{div_done: div_done, scan_done: scan_done};
  assign fill_idx  = free_r ? free_idx_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r <= 1'b0;
      valid_r     <= '0;
      evt_r       <= SW'(1);
      for (int k = 0; k < D; k++) begin
        use_r[k] <= '0;
        ins_r[k] <= '0;
      end
    end else begin
      if (cmd.scan_start) begin
        scan_busy_r <= 1'b1;
        scan_i_r    <= '0;
        found_r     <= 1'b0;
        free_r      <= 1'b0;
        best_r      <= '0;
        freed_r     <= '0;
      end else if (scan_busy_r && scan_i_r != scan_lim) begin
        scan_i_r <= scan_i_r + CW'(1);
        if (is_mgmt) begin
          if (kill) begin
            valid_r[sidx] <= 1'b0;
            freed_r       <= freed_r + CW'(1);
          end
        end else begin
          if (match && !found_r) begin
            found_r     <= 1'b1;
            found_idx_r <= sidx;
          end
          if (!valid_r[sidx] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= sidx;
          end
          if (scan_i_r == '0 || cur_stamp < best_stamp_r) begin
            best_r       <= sidx;
            best_stamp_r <= cur_stamp;
          end
        end
      end
      if (cmd.finish) begin
        scan_busy_r <= 1'b0;
        if (cmd_r == tlbflt_pkg::CMD_LOOKUP && found_r) begin
          use_r[found_idx_r] <= evt_r;
          evt_r <= evt_r + SW'(1);
        end else if (cmd_r == tlbflt_pkg::CMD_FILL) begin
          valid_r[fill_idx] <= 1'b1;
          use_r[fill_idx]   <= evt_r;
          ins_r[fill_idx]   <= evt_r;
          evt_r <= evt_r + SW'(1);
        end
      end
    end
  end

  // page and frame stores, written on fill
  always_ff @(posedge clk) begin
    if (cmd.finish && cmd_r == tlbflt_pkg::CMD_FILL) begin
      page_mem[fill_idx]  <= page_r;
      frame_mem[fill_idx] <= frame_r;
    end
  end

  // result register
  logic        hit_r;
  logic [31:0] phys_r, pn_r, l1o_r;
  logic [15:0] l2o_r;
  logic [3:0]  eidx_r;
  logic [4:0]  fc_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit_r  <= 1'b0;
      phys_r <= '0;
      pn_r   <= '0;
      l1o_r  <= '0;
      l2o_r  <= '0;
      eidx_r <= '0;
      fc_r   <= '0;
      if (is_mgmt) begin
        fc_r <= 5'(freed_r);
      end else begin
        pn_r  <= page_r;
        l1o_r <= l1_r;
        l2o_r <= l2_r;
        if (cmd_r == tlbflt_pkg::CMD_FILL) begin
          hit_r  <= 1'b1;
          phys_r <= frame_r + offset_r;
          eidx_r <= 4'(fill_idx);
        end else if (found_r) begin
          hit_r  <= 1'b1;
          phys_r <= frame_mem[found_idx_r] + offset_r;
          eidx_r <= 4'(found_idx_r);
        end
      end
    end
  end

  assign out_hit                = hit_r;
  assign out_physical_address   = phys_r;
  assign out_page_number        = pn_r;
  assign out_first_level_index  = l1o_r;
  assign out_second_level_index = l2o_r;
  assign out_entry_index        = eidx_r;
  assign out_freed_count        = fc_r;
endmodule
`default_nettype wire

>>> hw/rtl/tlb_fifo_lru_translate_core.sv
// Top level: fully associative TLB with FIFO or LRU replacement
// Usage:
//   in_valid/in_stall carries one command (lookup, fill, invalidate by
//   frame, flush) with address and frame; out_valid/out_stall returns one
//   result per command. Configuration is written via cfg_we/cfg_index/
//   cfg_data; the user must do so while idle, unenforced by the block.
// Sequencing:
//   One transaction is in flight at a time. The shared bit-serial divider
//   first computes address / page size and then page / entries_per_table;
//   the entry scan (one entry per cycle, at most 16) runs during the second
//   divide. In the SCAN state the finish command then updates the entries
//   and registers the result; out_valid is raised in the DONE state, and a
//   new transaction is accepted only once the result is taken and the
//   controller is back in idle.
// Reset: rst_n (synchronous) clears all valid bits and stamps, sets the
//   event counter to one and loads the configuration defaults.
// Stall: the result is held in the output register while out_stall is
//   high; no new transaction is accepted until it is taken.
`default_nettype none
module tlb_fifo_lru_translate_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_logical_address,
  input  wire logic [31:0] in_frame_base,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic [31:0]      out_physical_address,
  output logic [31:0]      out_page_number,
  output logic [31:0]      out_first_level_index,
  output logic [15:0]      out_second_level_index,
  output logic [3:0]       out_entry_index,
  output logic [4:0]       out_freed_count
);
  tlbflt_pkg::dp_cmd_t cmd;
  tlbflt_pkg::dp_sts_t sts;

  tlbflt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  tlbflt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .in_command(in_command),
    .in_logical_address(in_logical_address), .in_frame_base(in_frame_base),
    .out_hit(out_hit), .out_physical_address(out_physical_address),
    .out_page_number(out_page_number),
    .out_first_level_index(out_first_level_index),
    .out_second_level_index(out_second_level_index),
    .out_entry_index(out_entry_index), .out_freed_count(out_freed_count)
  );
endmodule
`default_nettype wire

>>> hw/rtl/tlbflt_chk.sv
// Port-level checker for the TLB top level, with bind
`default_nettype none
`include "tlb_fifo_lru_translate_core_macros.svh"
module tlbflt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_hit,
  input wire logic [31:0] out_physical_address,
  input wire logic [4:0]  out_freed_count
);
  // one transaction at a time: no intake while a result waits
  `TLB_ASSERT_IMP(a_no_accept_with_result, clk, rst_n, out_valid, in_stall)
  // a result stays until taken
  `TLB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // a miss reports a zero address
  `TLB_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_hit,
                  out_physical_address == 32'd0)
  // freed count never exceeds depth
  `TLB_ASSERT_IMP(a_freed_range, clk, rst_n, out_valid, out_freed_count <= 5'd16)
  // an accepted transaction closes the input
  `TLB_ASSERT_NEXT(a_accept_closes, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule
bind tlb_fifo_lru_translate_core tlbflt_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
  .out_physical_address(out_physical_address), .out_freed_count(out_freed_count)
);
`default_nettype wire
